FILE: src/geo_pkg.sv
// Shared types, widths and state encodings for the gated Euclidean odometer.
package geo_pkg;

  localparam int unsigned PosW   = 24;                   // Q15.8 position / depth
  localparam int unsigned DiffW  = PosW + 1;             // signed difference
  localparam int unsigned RadW   = 2 * DiffW;            // sum of two squares
  localparam int unsigned RootW  = RadW / 2;             // root bits
  localparam int unsigned RemW   = RootW + 2;            // partial remainder
  localparam int unsigned CntW   = $clog2(RootW);        // root step counter
  localparam int unsigned SumW   = 40;                   // Q32.8 total

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_ADD,
    ST_ROOT,
    ST_ACC,
    ST_OUT
  } geo_state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic set_ref;    // take reference from the input ports
    logic load_cur;   // capture the input position
    logic diff;       // form dx, dy and move the reference
    logic sq_x;       // square dx
    logic sq_y;       // square dy
    logic root_init;  // add squares, clear the root unit
    logic root_step;  // one root digit
    logic acc;        // saturating add into the total
    logic emit;       // load the output register
  } geo_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic gate;       // input depth above threshold
    logic root_last;  // final root digit in this cycle
  } geo_sts_t;

endpackage

FILE: src/geo_ctrl.sv
// Controller state machine: pending flags, reference flag, sequencing and output valid.
module geo_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            x_fresh_i,
  input  logic            y_fresh_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  geo_pkg::geo_sts_t sts_i,
  output geo_pkg::geo_cmd_t cmd_o
);
  import geo_pkg::*;

  geo_state_e state_q, state_d;
  logic       x_pend_q, x_pend_d;
  logic       y_pend_q, y_pend_d;
  logic       have_ref_q, have_ref_d;
  logic       out_valid_q, out_valid_d;
  logic       xp, yp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_pend_q    <= 1'b0;
      y_pend_q    <= 1'b0;
      have_ref_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_pend_q    <= x_pend_d;
      y_pend_q    <= y_pend_d;
      have_ref_q  <= have_ref_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    x_pend_d    = x_pend_q;
    y_pend_d    = y_pend_q;
    have_ref_d  = have_ref_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    xp          = x_pend_q | x_fresh_i;
    yp          = y_pend_q | y_fresh_i;

    // Drop the output once taken.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (xp && yp) begin
            x_pend_d = 1'b0;
            y_pend_d = 1'b0;
            if (!have_ref_q) begin
              cmd_o.set_ref = 1'b1;
              have_ref_d    = 1'b1;
            end else if (sts_i.gate) begin
              cmd_o.load_cur = 1'b1;
              state_d        = ST_DIFF;
            end else begin
              cmd_o.set_ref = 1'b1;
              state_d       = ST_OUT;
            end
          end else begin
            x_pend_d = xp;
            y_pend_d = yp;
          end
        end
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_SQX;
      end
      ST_SQX: begin
        cmd_o.sq_x = 1'b1;
        state_d    = ST_SQY;
      end
      ST_SQY: begin
        cmd_o.sq_y = 1'b1;
        state_d    = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.root_init = 1'b1;
        state_d         = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_last) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/geo_dpath.sv
// Datapath: threshold, reference, squares, bit-serial root, saturating total.
module geo_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic signed [geo_pkg::PosW-1:0] cfg_thr_i,
  input  logic signed [geo_pkg::PosW-1:0] pos_x_i,
  input  logic signed [geo_pkg::PosW-1:0] pos_y_i,
  input  logic signed [geo_pkg::PosW-1:0] depth_i,
  input  geo_pkg::geo_cmd_t             cmd_i,
  output geo_pkg::geo_sts_t             sts_o,
  output logic [geo_pkg::SumW-1:0]      total_distance_o
);
  import geo_pkg::*;

  logic signed [PosW-1:0]  thr_q;
  logic signed [PosW-1:0]  last_x_q, last_y_q;
  logic signed [PosW-1:0]  cur_x_q, cur_y_q;
  logic signed [DiffW-1:0] dx_q, dy_q;
  logic signed [DiffW-1:0] mul_a;
  logic signed [RadW-1:0]  mul_p;
  logic [RadW-1:0]         sq_q, prod_q;
  logic [RadW-1:0]         rad_q;
  logic [RemW-1:0]         rem_q, rem_sh, trial;
  logic [RootW-1:0]        root_q;
  logic [CntW-1:0]         cnt_q;
  logic                    ge;
  logic [SumW-1:0]         sum_q, out_q;
  logic [SumW:0]           sum_ext;

  // One shared multiplier for both squares.
  assign mul_a = cmd_i.sq_y ? dy_q : dx_q;
  assign mul_p = mul_a * mul_a;

  // Root digit: shift in two radicand bits, try subtracting 4*root+1.
  assign rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  assign sum_ext = {1'b0, sum_q} + {{(SumW + 1 - RootW){1'b0}}, root_q};

  assign sts_o.gate      = depth_i > thr_q;
  assign sts_o.root_last = cnt_q == CntW'(RootW - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= '0;
      last_x_q <= '0;
      last_y_q <= '0;
      sum_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_thr_i;
      end
      if (cmd_i.set_ref) begin
        last_x_q <= pos_x_i;
        last_y_q <= pos_y_i;
      end else if (cmd_i.diff) begin
        last_x_q <= cur_x_q;
        last_y_q <= cur_y_q;
      end
      if (cmd_i.acc) begin
        sum_q <= sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cur) begin
      cur_x_q <= pos_x_i;
      cur_y_q <= pos_y_i;
    end
    if (cmd_i.diff) begin
      dx_q <= DiffW'(cur_x_q) - DiffW'(last_x_q);
      dy_q <= DiffW'(cur_y_q) - DiffW'(last_y_q);
    end
    if (cmd_i.sq_x) begin
      sq_q <= mul_p;
    end
    if (cmd_i.sq_y) begin
      prod_q <= mul_p;
    end
    if (cmd_i.root_init) begin
      rad_q  <= sq_q + prod_q;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[RootW-2:0], ge};
      cnt_q  <= cnt_q + 1'b1;
    end
    if (cmd_i.emit) begin
      out_q <= sum_q;
    end
  end

  assign total_distance_o = out_q;

endmodule

FILE: src/gated_euclidean_odometer.sv
// Top level of the depth-gated Euclidean odometer.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+----------------------------------
//   cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_depth_threshold_i (s24)
//   in      | in        | in_valid_i / in_ready_o   | pos_x_i, pos_y_i, depth_i (s24),
//           |           |                           | x_fresh_i, y_fresh_i
//   out     | out       | out_valid_o / out_ready_i | total_distance_o (u40, Q32.8)
//
// A tick that emits nothing leaves the controller idle and the next tick may follow
// at once. A tick that emits with depth at or below threshold moves the reference and
// goes straight to the output. A tick that adds distance runs difference, two squarings
// on one shared multiplier, add, the 25-step bit-serial root unit and accumulate.
// Reset clears the threshold, reference, pending flags and total; no clearing pass.
// The finished total sits in an output register, so a new tick is taken while it
// waits; a stalled output holds the controller only when the next total is ready.
module gated_euclidean_odometer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic signed [geo_pkg::PosW-1:0] cfg_depth_threshold_i,
  // tick input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [geo_pkg::PosW-1:0] pos_x_i,
  input  logic signed [geo_pkg::PosW-1:0] pos_y_i,
  input  logic signed [geo_pkg::PosW-1:0] depth_i,
  input  logic                            x_fresh_i,
  input  logic                            y_fresh_i,
  // total output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [geo_pkg::SumW-1:0]        total_distance_o
);
  import geo_pkg::*;

  geo_cmd_t cmd;
  geo_sts_t sts;

  // Config must be written only while idle; the block does not enforce it, so always take the transaction.
  assign cfg_ready_o = 1'b1;

  // Sequence each tick: latch flags, set reference or run the distance update.
  geo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .x_fresh_i  (x_fresh_i),
    .y_fresh_i  (y_fresh_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold positions, compute the step length and advance the total.
  geo_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_thr_i       (cfg_depth_threshold_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .depth_i         (depth_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .total_distance_o(total_distance_o)
  );

endmodule

FILE: src/geo_checker.sv
// Port-level checks for the gated Euclidean odometer, bound to the top level.
module geo_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic signed [geo_pkg::PosW-1:0] cfg_depth_threshold_i,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic signed [geo_pkg::PosW-1:0] pos_x_i,
  input logic signed [geo_pkg::PosW-1:0] pos_y_i,
  input logic signed [geo_pkg::PosW-1:0] depth_i,
  input logic                            x_fresh_i,
  input logic                            y_fresh_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [geo_pkg::SumW-1:0]        total_distance_o
);
  import geo_pkg::*;

  logic [SumW-1:0] last_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_total_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      last_total_q <= total_distance_o;
    end
  end

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(total_distance_o))
    else $error("output changed while stalled");

  // The total never goes down.
  a_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> total_distance_o >= last_total_q)
    else $error("total distance decreased");

  // A tick with no fresh flag does nothing and leaves the block ready.
  a_stale_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !x_fresh_i && !y_fresh_i |=> in_ready_o)
    else $error("stale tick started work");

  // Work starts only on an input transaction.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && in_ready_o))
    else $error("busy without an input transaction");

endmodule

bind gated_euclidean_odometer geo_checker u_geo_checker (.*);
